// ----- rtl/ncd_pkg.sv -----
// ncd_pkg: shared constants, function codes and controller/datapath structs
// for the note change detector; depends on nothing
package ncd_pkg;

   localparam int PEAK_ENTRIES_DEF = 12;
   localparam int IDX_W            = 4;
   localparam int AMP_W            = 24;
   localparam int FREQ_W           = 24;
   localparam int PCT_W            = 7;
   localparam int CAR_W            = 8;
   localparam int NUM_W            = FREQ_W + 2;
   localparam int HARM_SHIFT       = 20;

   localparam logic [20:0] HARM_UP   = 21'd1079302;
   localparam logic [19:0] HARM_DOWN = 20'd1018725;
   localparam logic [6:0]  HUNDRED   = 7'd100;

   localparam logic [23:0] TOL_RESET   = 24'd2560;
   localparam logic [6:0]  DECAY_RESET = 7'd50;
   localparam logic [7:0]  CARRY_RESET = 8'd50;

   localparam logic [1:0] FUNC_LOAD_PREV = 2'd0;
   localparam logic [1:0] FUNC_LOAD_CUR  = 2'd1;
   localparam logic [1:0] FUNC_EVAL      = 2'd2;

   localparam logic [1:0] CSR_TOL   = 2'd0;
   localparam logic [1:0] CSR_DECAY = 2'd1;
   localparam logic [1:0] CSR_CARRY = 2'd2;

   typedef struct packed {
      logic             load;
      logic             eval_start;
      logic             max_step;
      logic             row_start;
      logic             pair_eval;
      logic             harm_init;
      logic             div_step;
      logic             f_calc;
      logic             mul_lo;
      logic             mul_hi;
      logic             pair_commit;
      logic             swap;
      logic [IDX_W-1:0] i_idx;
      logic [IDX_W-1:0] j_idx;
   } cmd_type;

   typedef struct packed {
      logic ac_zero;
      logic ap_zero;
      logic base_zero;
      logic hit;
      logic row_fail;
   } sts_type;

endpackage

// ----- rtl/ncd_datapath.sv -----
// ncd_datapath: peak tables, config registers, restoring divider and the
// compare logic of the note change detector; depends on ncd_pkg
module ncd_datapath import ncd_pkg::*; #(
   parameter int PEAK_ENTRIES = PEAK_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_index,
   input  logic [AMP_W-1:0]  req_amplitude,
   input  logic [FREQ_W-1:0] req_frequency,
   input  logic [PCT_W-1:0]  req_new_note_percent,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   localparam int IW = (PEAK_ENTRIES > 1) ? $clog2(PEAK_ENTRIES) : 1;

   logic [AMP_W-1:0]  pa_ff [PEAK_ENTRIES];
   logic [FREQ_W-1:0] pf_ff [PEAK_ENTRIES];
   logic [AMP_W-1:0]  ca_ff [PEAK_ENTRIES];
   logic [FREQ_W-1:0] cf_ff [PEAK_ENTRIES];

   logic [23:0]       tol_ff;
   logic [PCT_W-1:0]  dec_ff;
   logic [CAR_W-1:0]  car_ff;
   logic [PCT_W-1:0]  pct_ff;
   logic [AMP_W-1:0]  strong_ff;
   logic              matched_ff;
   logic [AMP_W-1:0]  best_ff;
   logic              hit_ff;
   logic [NUM_W-1:0]  num_ff, numk_ff, rem_ff;
   logic [NUM_W-2:0]  den_ff;
   logic [FREQ_W-1:0] t_ff;
   logic [NUM_W-2:0]  f_ff;
   logic              lo_ok_ff;

   logic [AMP_W-1:0]  ac, ap;
   logic [FREQ_W-1:0] fc, fp, base, tv, diff;
   logic [NUM_W-1:0]  rem_sh, num_sub;
   logic              close;
   logic [43:0]       t_scaled;
   logic              load_ok;

   assign ac = ca_ff[cmd.i_idx[IW-1:0]];
   assign fc = cf_ff[cmd.i_idx[IW-1:0]];
   assign ap = pa_ff[cmd.j_idx[IW-1:0]];
   assign fp = pf_ff[cmd.j_idx[IW-1:0]];

   // first pass tests the current frequency against previous base
   assign base = cmd.swap ? fc : fp;
   assign tv   = cmd.swap ? fp : fc;
   assign diff = (fc > fp) ? (fc - fp) : (fp - fc);
   assign close = (diff <= tol_ff) && (ac < ap) &&
                  (32'(ac) * 32'(HUNDRED) >= 32'(ap) * 32'(dec_ff));
   assign rem_sh  = {rem_ff[NUM_W-2:0], num_ff[NUM_W-1]};
   assign num_sub = numk_ff - rem_ff;
   assign t_scaled = {t_ff, 20'd0};
   assign load_ok = ({1'b0, req_index} < 5'(PEAK_ENTRIES));

   always_comb begin
      sts.ac_zero   = (ac == '0);
      sts.ap_zero   = (ap == '0);
      sts.base_zero = (base == '0);
      sts.hit       = hit_ff;
      if (matched_ff) begin
         sts.row_fail = (32'(best_ff) * 32'(HUNDRED) < 32'(ac) * 32'(car_ff));
      end else begin
         sts.row_fail = (32'(ac) * 32'(HUNDRED) >= 32'(strong_ff) * 32'(pct_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PEAK_ENTRIES; k++) begin
            pa_ff[k] <= '0;
            pf_ff[k] <= '0;
            ca_ff[k] <= '0;
            cf_ff[k] <= '0;
         end
      end else if (cmd.load && load_ok) begin
         if (req_func == FUNC_LOAD_PREV) begin
            pa_ff[req_index[IW-1:0]] <= req_amplitude;
            pf_ff[req_index[IW-1:0]] <= req_frequency;
         end else if (req_func == FUNC_LOAD_CUR) begin
            ca_ff[req_index[IW-1:0]] <= req_amplitude;
            cf_ff[req_index[IW-1:0]] <= req_frequency;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         dec_ff <= DECAY_RESET;
         car_ff <= CARRY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOL:   tol_ff <= csr_wdata;
            CSR_DECAY: dec_ff <= csr_wdata[PCT_W-1:0];
            CSR_CARRY: car_ff <= csr_wdata[CAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_start) begin
         pct_ff    <= req_new_note_percent;
         strong_ff <= '0;
      end
      if (cmd.max_step && ac > strong_ff) begin
         strong_ff <= ac;
      end
      if (cmd.row_start) begin
         matched_ff <= 1'b0;
         best_ff    <= '0;
      end
      if (cmd.pair_eval) begin
         hit_ff <= close || (cmd.i_idx == cmd.j_idx);
      end
      if (cmd.harm_init) begin
         num_ff  <= {1'b0, tv, 1'b0} + NUM_W'(base);
         numk_ff <= {1'b0, tv, 1'b0} + NUM_W'(base);
         den_ff  <= {base, 1'b0};
         rem_ff  <= '0;
         t_ff    <= tv;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
         end else begin
            rem_ff <= rem_sh;
         end
      end
      if (cmd.f_calc) begin
         // rounded multiple times base, taken from the remainder
         f_ff <= num_sub[NUM_W-1:1];
      end
      if (cmd.mul_lo) begin
         lo_ok_ff <= (45'(f_ff) * 45'(HARM_DOWN) <= 45'(t_scaled));
      end
      if (cmd.mul_hi && lo_ok_ff &&
          (46'(t_scaled) <= 46'(f_ff) * 46'(HARM_UP))) begin
         hit_ff <= 1'b1;
      end
      if (cmd.pair_commit && hit_ff) begin
         matched_ff <= 1'b1;
         if (ap > best_ff) begin
            best_ff <= ap;
         end
      end
   end

endmodule

// ----- rtl/ncd_control.sv -----
// ncd_control: sequencer that walks the peak pairs of an evaluate and
// drives the datapath; depends on ncd_pkg
module ncd_control import ncd_pkg::*; #(
   parameter int PEAK_ENTRIES = PEAK_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_func,
   output logic       busy,
   output logic       rsp_strobe,
   output logic       rsp_same_note,
   output cmd_type    cmd,
   input  sts_type    sts
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(PEAK_ENTRIES - 1);
   localparam logic [4:0] DIV_LAST = 5'(NUM_W - 1);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_MAX    = 11'b00000000010,
      S_ROW    = 11'b00000000100,
      S_PAIR   = 11'b00000001000,
      S_PCHK   = 11'b00000010000,
      S_HARM   = 11'b00000100000,
      S_DIV    = 11'b00001000000,
      S_FCALC  = 11'b00010000000,
      S_MLO    = 11'b00100000000,
      S_MHI    = 11'b01000000000,
      S_COMMIT = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]       pass_ff, pass_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             strobe_ff, strobe_in, same_ff, same_in;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_same_note = same_ff;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      same_in   = same_ff;
      cmd       = '0;
      cmd.i_idx = i_ff;
      cmd.j_idx = j_ff;
      cmd.swap  = pass_ff[0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_LOAD_PREV || req_func == FUNC_LOAD_CUR) begin
                  cmd.load = 1'b1;
               end else if (req_func == FUNC_EVAL) begin
                  cmd.eval_start = 1'b1;
                  i_in = '0;
                  state_in = S_MAX;
               end
            end
         end
         S_MAX: begin
            cmd.max_step = 1'b1;
            if (i_ff == LAST) begin
               i_in = '0;
               state_in = S_ROW;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_ROW: begin
            if (sts.ac_zero) begin
               if (i_ff == LAST) begin
                  strobe_in = 1'b1;
                  same_in   = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               cmd.row_start = 1'b1;
               j_in = '0;
               state_in = S_PAIR;
            end
         end
         S_PAIR: begin
            if (sts.ap_zero) begin
               if (j_ff == LAST) begin
                  state_in = S_COMMIT;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               cmd.pair_eval = 1'b1;
               pass_in  = 2'd0;
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (sts.hit || pass_ff == 2'd2) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_HARM;
            end
         end
         S_HARM: begin
            if (sts.base_zero) begin
               pass_in  = pass_ff + 1'b1;
               state_in = S_PCHK;
            end else begin
               cmd.harm_init = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FCALC;
            end
         end
         S_FCALC: begin
            cmd.f_calc = 1'b1;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            pass_in  = pass_ff + 1'b1;
            state_in = S_PCHK;
         end
         S_COMMIT: begin
            // also reached after a skipped last pair: the row is judged here
            if (pass_ff != 2'd3 && !sts.ap_zero) begin
               cmd.pair_commit = 1'b1;
            end
            if (j_ff != LAST || (!sts.ap_zero && pass_ff != 2'd3)) begin
               if (j_ff != LAST) begin
                  j_in = j_ff + 1'b1;
                  state_in = S_PAIR;
               end else begin
                  pass_in = 2'd3;
               end
            end else if (sts.row_fail) begin
               strobe_in = 1'b1;
               same_in   = 1'b0;
               state_in  = S_IDLE;
            end else if (i_ff == LAST) begin
               strobe_in = 1'b1;
               same_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_ROW;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         pass_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         pass_ff   <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      cnt_ff  <= cnt_in;
      same_ff <= same_in;
   end

endmodule

// ----- rtl/note_change_detector.sv -----
// note_change_detector: a load is a single transfer that leaves busy low, so loads can
// follow every cycle while not busy; an evaluate holds busy for the pair walk, in which
// a harmonic test runs the 26-step restoring divider and two tests per peak pair run at
// most; the result shows on rsp_strobe for one cycle, in the same cycle that busy falls;
// the receiver cannot stall; reset (synchronous, active high) clears both peak tables and
// loads the register defaults; depends on ncd_pkg, ncd_control, ncd_datapath
module note_change_detector import ncd_pkg::*; #(
   parameter int PEAK_ENTRIES = PEAK_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input transfer: start while not busy
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_index,
   input  logic [AMP_W-1:0]  req_amplitude,
   input  logic [FREQ_W-1:0] req_frequency,
   input  logic [PCT_W-1:0]  req_new_note_percent,
   // result transfer, one cycle strobe
   output logic              rsp_strobe,
   output logic              rsp_same_note,
   // register writes
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: pair walk, harmonic passes, divider step count
   ncd_control #(.PEAK_ENTRIES(PEAK_ENTRIES)) u_control (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_func      (req_func),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_same_note (rsp_same_note),
      .cmd           (cmd),
      .sts           (sts)
   );

   // tables, registers, divider and compares
   ncd_datapath #(.PEAK_ENTRIES(PEAK_ENTRIES)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_func             (req_func),
      .req_index            (req_index),
      .req_amplitude        (req_amplitude),
      .req_frequency        (req_frequency),
      .req_new_note_percent (req_new_note_percent),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

endmodule

// ----- dv/tb_note_change_detector.sv -----
// tb_note_change_detector: self-checking bench for the note change detector
// directed table then random load/evaluate traffic, checked against a local
// model of the peak tables; depends on ncd_pkg and note_change_detector
module tb_note_change_detector import ncd_pkg::*;;

   localparam int NPEAK = 12;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_func;
   logic [3:0]        req_index;
   logic [AMP_W-1:0]  req_amplitude;
   logic [FREQ_W-1:0] req_frequency;
   logic [PCT_W-1:0]  req_new_note_percent;
   logic              rsp_strobe;
   logic              rsp_same_note;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [23:0]       csr_wdata;

   note_change_detector uut (.*);

   // model copy of the peak tables and registers
   logic [23:0] m_prev_amp [NPEAK];
   logic [23:0] m_prev_freq[NPEAK];
   logic [23:0] m_cur_amp  [NPEAK];
   logic [23:0] m_cur_freq [NPEAK];
   logic [23:0] m_tol;
   logic [6:0]  m_decay;
   logic [7:0]  m_carry;

   bit   verdict_q[$];
   int   mismatches;
   int   verdicts_seen;
   int   evals_sent;

   // directed row: want is 0/1 when known by inspection, else 2 for model only
   typedef struct {
      logic [1:0]  func;
      logic [3:0]  idx;
      logic [23:0] amp;
      logic [23:0] freq;
      logic [6:0]  pct;
      int          want;
   } row_type;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // harmonic test of t against base, quarter tone either side
   function automatic bit is_harmonic(logic [23:0] base, logic [23:0] t);
      logic [63:0] m, f, scaled;
      if (base == 0) return 1'b0;
      m      = (2 * 64'(t) + 64'(base)) / (2 * 64'(base));
      f      = m * 64'(base);
      scaled = 64'(t) << HARM_SHIFT;
      return (f * 64'(HARM_DOWN) <= scaled) && (scaled <= f * 64'(HARM_UP));
   endfunction

   function automatic bit same_note_of(logic [6:0] pct);
      logic [63:0] strongest, ac, fc, ap, fp, best, diff;
      bit matched, hit;
      strongest = 0;
      for (int i = 0; i < NPEAK; i++)
         if (m_cur_amp[i] > strongest) strongest = m_cur_amp[i];
      for (int i = 0; i < NPEAK; i++) begin
         ac = m_cur_amp[i];
         fc = m_cur_freq[i];
         best = 0;
         matched = 0;
         if (ac == 0) continue;
         for (int j = 0; j < NPEAK; j++) begin
            ap = m_prev_amp[j];
            fp = m_prev_freq[j];
            if (ap == 0) continue;
            hit = (i == j) || is_harmonic(fp[23:0], fc[23:0]) ||
                  is_harmonic(fc[23:0], fp[23:0]);
            diff = fc > fp ? fc - fp : fp - fc;
            if (diff <= m_tol && ac < ap && ac * 100 >= ap * m_decay) hit = 1;
            if (hit) begin
               matched = 1;
               if (ap > best) best = ap;
            end
         end
         if (!matched) begin
            if (ac * 100 >= strongest * pct) return 1'b0;
         end else if (best * 100 < ac * m_carry) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // apply one accepted item to the model, queue its verdict if any
   task automatic model_item(row_type r);
      bit v;
      if (r.func == FUNC_EVAL) begin
         v = same_note_of(r.pct);
         if (r.want != 2 && v != bit'(r.want)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table verdict disagrees with model: table %0d model %0d", r.want, v);
         end
         verdict_q.insert(verdict_q.size(), v);
         evals_sent++;
      end else if ((r.func == FUNC_LOAD_PREV || r.func == FUNC_LOAD_CUR) && r.idx < NPEAK) begin
         if (r.func == FUNC_LOAD_PREV) begin
            m_prev_amp[r.idx]  = r.amp;
            m_prev_freq[r.idx] = r.freq;
         end else begin
            m_cur_amp[r.idx]  = r.amp;
            m_cur_freq[r.idx] = r.freq;
         end
      end
   endtask

   // one transfer: raise start, hold until accepted
   task automatic send(row_type r);
      req_func             <= r.func;
      req_index            <= r.idx;
      req_amplitude        <= r.amp;
      req_frequency        <= r.freq;
      req_new_note_percent <= r.pct;
      start                <= 1'b1;
      do @(posedge clock); while (busy);
      model_item(r);
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait for all verdicts, then a margin for trailing loads
   task automatic drain();
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TOL)        m_tol   = val;
      else if (idx == CSR_DECAY) m_decay = val[6:0];
      else if (idx == CSR_CARRY) m_carry = val[7:0];
   endtask

   // result checker, sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         verdicts_seen++;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict %0d", rsp_same_note);
         end else begin
            if (rsp_same_note !== verdict_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("same_note mismatch: expected %0d actual %0b",
                           verdict_q[0], rsp_same_note);
            end
            void'(verdict_q.pop_front());
         end
      end
   end

   function automatic row_type mk(logic [1:0] f, logic [3:0] i, logic [23:0] a,
                                  logic [23:0] fr, logic [6:0] p, int w);
      row_type r;
      r.func = f; r.idx = i; r.amp = a; r.freq = fr; r.pct = p; r.want = w;
      return r;
   endfunction

   // random peak frequency, mostly harmonic-rich low values, sometimes wide
   function automatic logic [23:0] pick_freq(logic [23:0] fund);
      case ($urandom_range(0, 5))
         0: return 24'($urandom_range(0, 24'hFFFFFF));
         1: return 24'(fund * $urandom_range(1, 6));
         2: return 24'(fund + $urandom_range(0, 6000) - 3000);
         3: return fund;
         default: return 24'($urandom_range(0, 24'h0FFFFF));
      endcase
   endfunction

   initial begin
      row_type     dir[$];
      row_type     r;
      logic [23:0] fund;
      int          nrand;

      clock = 0; reset = 1; start = 0; req_func = 0; req_index = 0;
      req_amplitude = 0; req_frequency = 0; req_new_note_percent = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      mismatches = 0; verdicts_seen = 0; evals_sent = 0;
      for (int k = 0; k < NPEAK; k++) begin
         m_prev_amp[k] = 0; m_prev_freq[k] = 0; m_cur_amp[k] = 0; m_cur_freq[k] = 0;
      end
      m_tol = TOL_RESET; m_decay = DECAY_RESET; m_carry = CARRY_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty tables, extremes, unused code, bad index
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 0, 1));        // all empty
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  0, 24'hFFFFFF, 24'hFFFFFF, 0, 2));
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 100, 0));      // unmatched, strongest
      dir.insert(dir.size(), mk(FUNC_LOAD_PREV, 0, 24'hFFFFFF, 0, 0, 2));// same index match
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 100, 1));
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  5, 1000, 0, 0, 2));     // zero freq, no harmonic
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 0, 0));        // zero pct: unmatched trips
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 127, 2));
      dir.insert(dir.size(), mk(FUNC_LOAD_PREV, 3, 5000, 24'd25600, 0, 2));
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  5, 1000, 24'd51200, 0, 2)); // octave harmonic
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 50, 2));
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  5, 4000, 24'd26000, 0, 2)); // close, decaying
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 1, 2));
      dir.insert(dir.size(), mk(FUNC_UNUSED,    5, 0, 0, 0, 2));        // unused code
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  4'd15, 7, 7, 0, 2));    // index out of range
      dir.insert(dir.size(), mk(FUNC_LOAD_PREV, 4'd12, 7, 7, 0, 2));
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  11, 1, 24'd1, 0, 2));   // multiple rounds to zero
      dir.insert(dir.size(), mk(FUNC_LOAD_PREV, 11, 24'hFFFFFF, 24'd300, 0, 2));
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 100, 2));
      dir.insert(dir.size(), mk(FUNC_LOAD_CUR,  0, 0, 0, 0, 2));        // clear current entry 0 again
      dir.insert(dir.size(), mk(FUNC_EVAL,      0, 0, 0, 127, 2));
      foreach (dir[k]) send(dir[k]);
      drain();

      // random phases with different register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(CSR_TOL, 24'd0); write_csr(CSR_DECAY, 24'd0);
                     write_csr(CSR_CARRY, 24'd0); end
            1: begin write_csr(CSR_TOL, 24'hFFFFFF); write_csr(CSR_DECAY, 24'd127);
                     write_csr(CSR_CARRY, 24'd255); end
            2: begin write_csr(CSR_TOL, 24'd2560); write_csr(CSR_DECAY, 24'd100);
                     write_csr(CSR_CARRY, 24'd100); end
            3: write_csr(CSR_UNMAPPED, 24'h123456);              // unmapped index
            default: begin write_csr(CSR_TOL, 24'($urandom_range(0, 24'h00FFFF)));
                     write_csr(CSR_DECAY, 24'($urandom_range(0, 127)));
                     write_csr(CSR_CARRY, 24'($urandom_range(0, 255))); end
         endcase
         nrand = 0;
         while (nrand < 185) begin
            // a well-formed window: fill both tables then evaluate
            fund = 24'($urandom_range(2560, 256000));
            for (int k = 0; k < NPEAK && nrand < 185; k++) begin
               r = mk(2'($urandom_range(0, 1)), 4'($urandom_range(0, 11)),
                      ($urandom_range(0, 4) == 0) ? 24'd0 :
                      (($urandom_range(0, 9) == 0) ? 24'hFFFFFF :
                       24'($urandom_range(1, 24'hFFFFFF))),
                      pick_freq(fund), 7'($urandom_range(0, 127)), 2);
               if ($urandom_range(0, 15) == 0) r.func = 2'($urandom_range(0, 3));
               if ($urandom_range(0, 15) == 0) r.idx  = 4'($urandom_range(0, 15));
               send(r);
               nrand++;
               if (ph < 5 && $urandom_range(0, 5) == 0) idle($urandom_range(1, 7));
            end
            send(mk(FUNC_EVAL, 4'($urandom_range(0, 15)), 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)), 7'($urandom_range(0, 127)), 2));
            nrand++;
            if (ph < 5 && $urandom_range(0, 3) == 0) idle($urandom_range(1, 7));
            // hold off until the pipeline is empty now and then
            if (ph < 5 && $urandom_range(0, 7) == 0) drain();
         end
         drain();
      end

      if (mismatches == 0 && verdict_q.size() == 0)
         $display("tb_note_change_detector: clean");
      else
         $display("tb_note_change_detector: errors");
      $finish;
   end

   // watchdog against an evaluate that never ends
   initial begin
      #400000000;
      $display("tb_note_change_detector: errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ncd_pkg.sv
rtl/ncd_datapath.sv
rtl/ncd_control.sv
rtl/note_change_detector.sv
dv/tb_note_change_detector.sv
